// File: src/delay_sorted_action_queue_assert.svh
// Assertion macros used by the checker file of the timed-entry queue.
`ifndef DELAY_SORTED_ACTION_QUEUE_ASSERT_SVH
`define DELAY_SORTED_ACTION_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSAQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DSAQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/dsaq_pkg.sv
// Types and constants shared by the timed-entry queue modules.
package dsaq_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = 4;
  localparam int PTR_W   = 5;
  localparam logic [PTR_W-1:0] NIL = PTR_W'(ENTRIES);

  localparam logic [2:0] CMD_INSERT    = 3'd0;
  localparam logic [2:0] CMD_CANCEL    = 3'd1;
  localparam logic [2:0] CMD_ADVANCE   = 3'd2;
  localparam logic [2:0] CMD_DRAIN     = 3'd3;
  localparam logic [2:0] CMD_CHECK     = 3'd4;
  localparam logic [2:0] CMD_DUR_START = 3'd5;
  localparam logic [2:0] CMD_DUR_END   = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FREE  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] delay;
    logic [15:0] tag;
    idx_t        idx;
    logic [31:0] step;
  } item_t;

endpackage

// File: src/dsaq_req_if.sv
// Request channel interface of the timed-entry queue.
interface dsaq_req_if;
  import dsaq_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [31:0] delay_ticks;
  logic [15:0] action_tag;
  logic [3:0]  entry_index;
  logic [31:0] step_ticks;
  logic [31:0] time_now;
  modport source (output valid, cmd, delay_ticks, action_tag, entry_index, step_ticks,
                  time_now, input ready);
  modport sink (input valid, cmd, delay_ticks, action_tag, entry_index, step_ticks,
                time_now, output ready);
endinterface

// File: src/dsaq_res_if.sv
// Result channel interface of the timed-entry queue.
interface dsaq_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  given_index;
  logic [15:0] fired_tag;
  logic        last_fired;
  logic        is_expired;
  logic [31:0] next_interval;
  modport source (output valid, status, given_index, fired_tag, last_fired, is_expired,
                  next_interval, input ready);
  modport sink (input valid, status, given_index, fired_tag, last_fired, is_expired,
                next_interval, output ready);
endinterface

// File: src/dsaq_front.sv
// Front end: accepts requests, tracks duration mode and trims insert delays.
module dsaq_front (
  input  logic            clk,
  input  logic            rst_n,
  dsaq_req_if.sink        req,
  output logic            q_valid,
  input  logic            q_ready,
  output dsaq_pkg::item_t q_item
);
  import dsaq_pkg::*;

  logic        span_mode_r, span_mode_nxt;
  logic [31:0] span_start_r, span_start_nxt;
  logic [31:0] elapsed;
  logic [31:0] eff_delay;
  logic        accept;

  assign req.ready = q_ready;
  assign q_valid   = req.valid;
  assign accept    = req.valid && q_ready;
  assign elapsed   = req.time_now - span_start_r;

  always_comb begin
    if (!span_mode_r) begin
      eff_delay = req.delay_ticks;
    end else if (req.delay_ticks > elapsed) begin
      eff_delay = req.delay_ticks - elapsed;
    end else begin
      eff_delay = '0;
    end
  end

  always_comb begin
    q_item.cmd   = req.cmd;
    q_item.delay = eff_delay;
    q_item.tag   = req.action_tag;
    q_item.idx   = req.entry_index;
    q_item.step  = req.step_ticks;
  end

  always_comb begin
    span_mode_nxt  = span_mode_r;
    span_start_nxt = span_start_r;
    if (accept) begin
      case (req.cmd)
        CMD_DUR_START: begin
          span_mode_nxt  = 1'b1;
          span_start_nxt = req.time_now;
        end
        CMD_DUR_END: begin
          span_mode_nxt = 1'b0;
        end
        default: begin
          span_mode_nxt = span_mode_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_mode_r  <= 1'b0;
      span_start_r <= '0;
    end else begin
      span_mode_r  <= span_mode_nxt;
      span_start_r <= span_start_nxt;
    end
  end

endmodule

// File: src/dsaq_fifo.sv
// Short request queue between the front end and the list sequencer.
module dsaq_fifo #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  dsaq_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output dsaq_pkg::item_t pop_item
);
  import dsaq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t           mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: src/dsaq_back.sv
// Back end: walks the free, ready and sleeping lists and registers results.
module dsaq_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  dsaq_pkg::item_t q_item,
  dsaq_res_if.source      res
);
  import dsaq_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INS  = 4'd1;
  localparam logic [3:0] S_APPT = 4'd2;
  localparam logic [3:0] S_SRCH = 4'd3;
  localparam logic [3:0] S_LNKP = 4'd4;
  localparam logic [3:0] S_WALK = 4'd5;
  localparam logic [3:0] S_FREE = 4'd6;
  localparam logic [3:0] S_DEC  = 4'd7;
  localparam logic [3:0] S_EXP  = 4'd8;
  localparam logic [3:0] S_DRN  = 4'd9;
  localparam logic [3:0] S_EMIT = 4'd10;

  ptr_t        link_r [ENTRIES];
  logic [31:0] dly_r  [ENTRIES];
  logic [15:0] tag_r  [ENTRIES];

  logic [3:0]  state_r, state_nxt;
  item_t       it_r, it_nxt;
  ptr_t        free_head_r, free_head_nxt;
  ptr_t        ready_head_r, ready_head_nxt;
  ptr_t        ready_tail_r, ready_tail_nxt;
  ptr_t        sleep_head_r, sleep_head_nxt;
  ptr_t        cur_r, cur_nxt;
  ptr_t        prev_r, prev_nxt;
  idx_t        tmp_r, tmp_nxt;
  idx_t        oidx_r, oidx_nxt;
  logic        in_sleep_r, in_sleep_nxt;
  logic [1:0]  st_r, st_nxt;
  logic        exp_r, exp_nxt;

  logic        out_valid_r;
  logic [1:0]  out_status_r;
  idx_t        out_index_r;
  logic [15:0] out_tag_r;
  logic        out_last_r;
  logic        out_exp_r;
  logic [31:0] out_next_r;

  logic        o_load;
  logic [1:0]  o_status;
  idx_t        o_index;
  logic [15:0] o_tag;
  logic        o_last;
  logic        o_exp;
  logic        slot_free;

  idx_t        la, da, ta;
  ptr_t        lrd;
  logic [31:0] drd;
  logic [15:0] trd;
  logic [31:0] next_int;

  logic        lw_en, dw_en, tw_en;
  idx_t        lw_a, dw_a;
  ptr_t        lw_d;
  logic [31:0] dw_d;

  assign lrd       = link_r[la];
  assign drd       = dly_r[da];
  assign trd       = tag_r[ta];
  assign next_int  = sleep_head_r[PTR_W-1] ? '1 : drd;
  assign slot_free = !out_valid_r || res.ready;
  assign q_ready   = (state_r == S_IDLE);

  assign res.valid         = out_valid_r;
  assign res.status        = out_status_r;
  assign res.given_index   = out_index_r;
  assign res.fired_tag     = out_tag_r;
  assign res.last_fired    = out_last_r;
  assign res.is_expired    = out_exp_r;
  assign res.next_interval = out_next_r;

  always_comb begin
    state_nxt      = state_r;
    it_nxt         = it_r;
    free_head_nxt  = free_head_r;
    ready_head_nxt = ready_head_r;
    ready_tail_nxt = ready_tail_r;
    sleep_head_nxt = sleep_head_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    tmp_nxt        = tmp_r;
    oidx_nxt       = oidx_r;
    in_sleep_nxt   = in_sleep_r;
    st_nxt         = st_r;
    exp_nxt        = exp_r;
    la             = cur_r[IDX_W-1:0];
    da             = cur_r[IDX_W-1:0];
    ta             = ready_head_r[IDX_W-1:0];
    lw_en          = 1'b0;
    lw_a           = '0;
    lw_d           = NIL;
    dw_en          = 1'b0;
    dw_a           = '0;
    dw_d           = '0;
    tw_en          = 1'b0;
    o_load         = 1'b0;
    o_status       = st_r;
    o_index        = oidx_r;
    o_tag          = '0;
    o_last         = 1'b1;
    o_exp          = exp_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          it_nxt       = q_item;
          st_nxt       = ST_OK;
          exp_nxt      = 1'b0;
          oidx_nxt     = '0;
          prev_nxt     = NIL;
          in_sleep_nxt = 1'b0;
          case (q_item.cmd)
            CMD_INSERT: begin
              if (free_head_r[PTR_W-1]) begin
                st_nxt    = ST_NO_FREE;
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_INS;
              end
            end
            CMD_CANCEL: begin
              cur_nxt   = ready_head_r;
              state_nxt = S_WALK;
            end
            CMD_ADVANCE, CMD_CHECK: begin
              if (q_item.step == '0) begin
                cur_nxt   = ready_head_r;
                state_nxt = (q_item.cmd == CMD_CHECK) ? S_WALK : S_EMIT;
              end else begin
                cur_nxt   = sleep_head_r;
                state_nxt = S_DEC;
              end
            end
            CMD_DRAIN: begin
              if (ready_head_r[PTR_W-1]) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_DRN;
              end
            end
            default: begin
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_INS: begin
        la            = free_head_r[IDX_W-1:0];
        free_head_nxt = lrd;
        oidx_nxt      = free_head_r[IDX_W-1:0];
        tw_en         = 1'b1;
        dw_en         = 1'b1;
        dw_a          = free_head_r[IDX_W-1:0];
        dw_d          = it_r.delay;
        if (it_r.delay == '0) begin
          lw_en = 1'b1;
          lw_a  = free_head_r[IDX_W-1:0];
          lw_d  = NIL;
          if (ready_tail_r[PTR_W-1]) begin
            ready_head_nxt = free_head_r;
            ready_tail_nxt = free_head_r;
            state_nxt      = S_EMIT;
          end else begin
            tmp_nxt   = free_head_r[IDX_W-1:0];
            state_nxt = S_APPT;
          end
        end else begin
          cur_nxt   = sleep_head_r;
          prev_nxt  = NIL;
          state_nxt = S_SRCH;
        end
      end
      S_APPT: begin
        lw_en          = 1'b1;
        lw_a           = ready_tail_r[IDX_W-1:0];
        lw_d           = {1'b0, tmp_r};
        ready_tail_nxt = {1'b0, tmp_r};
        state_nxt      = (it_r.cmd == CMD_INSERT) ? S_EMIT : S_EXP;
      end
      S_SRCH: begin
        if (cur_r[PTR_W-1] || drd > it_r.delay) begin
          lw_en = 1'b1;
          lw_a  = oidx_r;
          lw_d  = cur_r;
          if (prev_r[PTR_W-1]) begin
            sleep_head_nxt = {1'b0, oidx_r};
            state_nxt      = S_EMIT;
          end else begin
            state_nxt = S_LNKP;
          end
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = lrd;
        end
      end
      S_LNKP: begin
        lw_en     = 1'b1;
        lw_a      = prev_r[IDX_W-1:0];
        lw_d      = {1'b0, oidx_r};
        state_nxt = S_EMIT;
      end
      S_DEC: begin
        if (cur_r[PTR_W-1]) begin
          state_nxt = S_EXP;
        end else begin
          dw_en   = 1'b1;
          dw_a    = cur_r[IDX_W-1:0];
          dw_d    = (drd > it_r.step) ? drd - it_r.step : '0;
          cur_nxt = lrd;
        end
      end
      S_EXP: begin
        la = sleep_head_r[IDX_W-1:0];
        da = sleep_head_r[IDX_W-1:0];
        if (!sleep_head_r[PTR_W-1] && drd == '0) begin
          sleep_head_nxt = lrd;
          lw_en          = 1'b1;
          lw_a           = sleep_head_r[IDX_W-1:0];
          lw_d           = NIL;
          if (ready_tail_r[PTR_W-1]) begin
            ready_head_nxt = sleep_head_r;
            ready_tail_nxt = sleep_head_r;
          end else begin
            tmp_nxt   = sleep_head_r[IDX_W-1:0];
            state_nxt = S_APPT;
          end
        end else if (it_r.cmd == CMD_CHECK) begin
          cur_nxt      = ready_head_r;
          prev_nxt     = NIL;
          in_sleep_nxt = 1'b0;
          state_nxt    = S_WALK;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_WALK: begin
        if (cur_r[PTR_W-1]) begin
          if (!in_sleep_r) begin
            in_sleep_nxt = 1'b1;
            cur_nxt      = sleep_head_r;
            prev_nxt     = NIL;
          end else begin
            st_nxt    = ST_NOT_FOUND;
            exp_nxt   = (it_r.cmd == CMD_CHECK);
            state_nxt = S_EMIT;
          end
        end else if (cur_r[IDX_W-1:0] == it_r.idx) begin
          if (in_sleep_r && it_r.cmd == CMD_CHECK) begin
            st_nxt    = ST_OK;
            exp_nxt   = 1'b0;
            state_nxt = S_EMIT;
          end else begin
            if (prev_r[PTR_W-1]) begin
              if (in_sleep_r) begin
                sleep_head_nxt = lrd;
              end else begin
                ready_head_nxt = lrd;
              end
            end else begin
              lw_en = 1'b1;
              lw_a  = prev_r[IDX_W-1:0];
              lw_d  = lrd;
            end
            if (!in_sleep_r && ready_tail_r == cur_r) begin
              ready_tail_nxt = prev_r;
            end
            exp_nxt   = (it_r.cmd == CMD_CHECK);
            state_nxt = S_FREE;
          end
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = lrd;
        end
      end
      S_FREE: begin
        lw_en         = 1'b1;
        lw_a          = it_r.idx;
        lw_d          = free_head_r;
        free_head_nxt = {1'b0, it_r.idx};
        st_nxt        = ST_OK;
        state_nxt     = S_EMIT;
      end
      S_DRN: begin
        la = ready_head_r[IDX_W-1:0];
        ta = ready_head_r[IDX_W-1:0];
        da = sleep_head_r[IDX_W-1:0];
        if (slot_free) begin
          o_load         = 1'b1;
          o_status       = ST_OK;
          o_index        = ready_head_r[IDX_W-1:0];
          o_tag          = trd;
          o_last         = lrd[PTR_W-1];
          o_exp          = 1'b0;
          lw_en          = 1'b1;
          lw_a           = ready_head_r[IDX_W-1:0];
          lw_d           = free_head_r;
          free_head_nxt  = ready_head_r;
          ready_head_nxt = lrd;
          if (lrd[PTR_W-1]) begin
            ready_tail_nxt = NIL;
            state_nxt      = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        da = sleep_head_r[IDX_W-1:0];
        if (slot_free) begin
          o_load    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        link_r[i] <= PTR_W'(i + 1);
        dly_r[i]  <= '0;
      end
    end else begin
      if (lw_en) begin
        link_r[lw_a] <= lw_d;
      end
      if (dw_en) begin
        dly_r[dw_a] <= dw_d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tw_en) begin
      tag_r[free_head_r[IDX_W-1:0]] <= it_r.tag;
    end
  end

  always_ff @(posedge clk) begin
    it_r   <= it_nxt;
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    tmp_r  <= tmp_nxt;
    oidx_r <= oidx_nxt;
    st_r   <= st_nxt;
    exp_r  <= exp_nxt;
    if (o_load) begin
      out_status_r <= o_status;
      out_index_r  <= o_index;
      out_tag_r    <= o_tag;
      out_last_r   <= o_last;
      out_exp_r    <= o_exp;
      out_next_r   <= next_int;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_head_r  <= '0;
      ready_head_r <= NIL;
      ready_tail_r <= NIL;
      sleep_head_r <= NIL;
      in_sleep_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_head_r  <= free_head_nxt;
      ready_head_r <= ready_head_nxt;
      ready_tail_r <= ready_tail_nxt;
      sleep_head_r <= sleep_head_nxt;
      in_sleep_r   <= in_sleep_nxt;
      if (o_load) begin
        out_valid_r <= 1'b1;
      end else if (res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// File: src/delay_sorted_action_queue.sv
// Top level of the sorted timed-entry queue.
// A pool of sixteen timed entries is kept in free, ready and sleeping linked lists. Requests
// pass through a short queue to a list sequencer that visits one entry per clock cycle, since
// each list store has a single read port; a drain waits while the result register is held.
// Drain gives one result per ready entry, duration and plain commands a single result. Insert
// walks past the sleeping entries whose delay is not larger; cancel and check walk the ready
// and then the sleeping list; advance and a check with a nonzero step pass every sleeping
// entry and then move each expired entry to the ready list. The worst case is a check with a
// nonzero step that expires every entry. Results wait in an output register while new requests
// are still taken into the queue.
module delay_sorted_action_queue #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  dsaq_req_if.sink   in_req,
  dsaq_res_if.source out_res
);
  import dsaq_pkg::*;

  logic  f_valid, f_ready, b_valid, b_ready;
  item_t f_item, b_item;

  dsaq_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (in_req),
    .q_valid (f_valid),
    .q_ready (f_ready),
    .q_item  (f_item)
  );

  dsaq_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_item   (b_item)
  );

  dsaq_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (b_valid),
    .q_ready (b_ready),
    .q_item  (b_item),
    .res     (out_res)
  );

endmodule

// File: src/dsaq_checker.sv
// Port checker for the timed-entry queue and its bind to the top level.
`include "delay_sorted_action_queue_assert.svh"

module dsaq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [3:0]  given_index,
  input logic [15:0] fired_tag,
  input logic        last_fired,
  input logic        is_expired,
  input logic [31:0] next_interval
);
  import dsaq_pkg::*;

  `DSAQ_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(given_index) && $stable(fired_tag) && $stable(next_interval))
  `DSAQ_ASSERT_IMP(a_multi_ok, clk, rst_n, out_valid && !last_fired, status == ST_OK && !is_expired)
  `DSAQ_ASSERT_IMP(a_fail_clean, clk, rst_n, out_valid && (status == ST_NO_FREE || status == ST_EMPTY), !is_expired && given_index == 4'd0 && last_fired)
  `DSAQ_ASSERT_IMP(a_tag_drain, clk, rst_n, out_valid && fired_tag != 16'd0, status == ST_OK && !is_expired)

endmodule

bind delay_sorted_action_queue dsaq_checker u_dsaq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_res.valid),
  .out_ready     (out_res.ready),
  .status        (out_res.status),
  .given_index   (out_res.given_index),
  .fired_tag     (out_res.fired_tag),
  .last_fired    (out_res.last_fired),
  .is_expired    (out_res.is_expired),
  .next_interval (out_res.next_interval)
);

// File: test/dsaq_tb_if.sv
`timescale 1ns / 1ps
// Testbench-side note: the channel interfaces come from the RTL; this file holds the tb types.
package dsaq_tb_pkg;
  import dsaq_pkg::*;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] delay_ticks;
    logic [15:0] action_tag;
    logic [3:0]  entry_index;
    logic [31:0] step_ticks;
    logic [31:0] time_now;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  given_index;
    logic [15:0] fired_tag;
    logic        last_fired;
    logic        is_expired;
    logic [31:0] next_interval;
  } answer_t;
endpackage

// File: test/delay_sorted_action_queue_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the sorted timed-entry queue with a list-level predictor.
module delay_sorted_action_queue_tb;
  import dsaq_pkg::*;
  import dsaq_tb_pkg::*;

  logic clk;
  logic rst_n;
  dsaq_req_if in_req();
  dsaq_res_if out_res();

  delay_sorted_action_queue dut (.clk(clk), .rst_n(rst_n), .in_req(in_req), .out_res(out_res));

  ptr_t        pool_link [ENTRIES];
  logic [31:0] pool_delay [ENTRIES];
  logic [15:0] pool_tag [ENTRIES];
  ptr_t        free_top, ready_top, sleep_top;
  logic [31:0] span_origin;
  logic        span_on;

  answer_t     pending_answers[$];
  int          error_count;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_cycles;
  int          live_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic ptr_t link_of(ptr_t i);
    if (i >= ENTRIES || pool_link[i] >= ENTRIES) return NIL;
    return pool_link[i];
  endfunction

  function automatic logic [31:0] head_delay();
    return (sleep_top < ENTRIES) ? pool_delay[sleep_top] : 32'hFFFF_FFFF;
  endfunction

  function automatic void push_ready(ptr_t i);
    ptr_t tail;
    ptr_t c;
    tail = NIL;
    c = ready_top;
    while (c < ENTRIES) begin
      tail = c;
      c = link_of(c);
    end
    pool_link[i] = NIL;
    if (tail == NIL) ready_top = i;
    else pool_link[tail] = i;
  endfunction

  function automatic bit remove_entry(ref ptr_t head, input ptr_t id);
    ptr_t prev;
    ptr_t c;
    prev = NIL;
    c = head;
    while (c < ENTRIES) begin
      if (c == id) begin
        if (prev == NIL) head = link_of(c);
        else pool_link[prev] = link_of(c);
        return 1'b1;
      end
      prev = c;
      c = link_of(c);
    end
    return 1'b0;
  endfunction

  function automatic void elapse(logic [31:0] steps);
    ptr_t c;
    if (steps == 0) return;
    c = sleep_top;
    while (c < ENTRIES) begin
      pool_delay[c] = (pool_delay[c] > steps) ? pool_delay[c] - steps : 32'd0;
      c = link_of(c);
    end
    while (sleep_top < ENTRIES && pool_delay[sleep_top] == 0) begin
      c = sleep_top;
      sleep_top = link_of(c);
      push_ready(c);
    end
  endfunction

  function automatic void expect_one(logic [1:0] st, logic [3:0] gi, logic ex);
    answer_t a;
    a = '{status: st, given_index: gi, fired_tag: 16'd0, last_fired: 1'b1,
          is_expired: ex, next_interval: head_delay()};
    pending_answers.push_back(a);
  endfunction

  function automatic void predict_queue(request_t r);
    ptr_t        id;
    ptr_t        prev;
    ptr_t        c;
    logic [31:0] d;
    logic [31:0] el;
    bit          found;
    answer_t     a;
    answer_t     drained[$];
    case (r.cmd)
      CMD_INSERT: begin
        id = free_top;
        if (id >= ENTRIES) begin
          expect_one(ST_NO_FREE, 4'd0, 1'b0);
        end else begin
          free_top = link_of(id);
          d = r.delay_ticks;
          if (span_on) begin
            el = r.time_now - span_origin;
            d = (d > el) ? d - el : 32'd0;
          end
          pool_tag[id] = r.action_tag;
          pool_delay[id] = d;
          if (d == 0) begin
            push_ready(id);
          end else begin
            prev = NIL;
            c = sleep_top;
            while (c < ENTRIES && pool_delay[c] <= d) begin
              prev = c;
              c = link_of(c);
            end
            pool_link[id] = c;
            if (prev == NIL) sleep_top = id;
            else pool_link[prev] = id;
          end
          live_count++;
          expect_one(ST_OK, id[3:0], 1'b0);
        end
      end
      CMD_CANCEL: begin
        found = remove_entry(ready_top, ptr_t'(r.entry_index));
        if (!found) found = remove_entry(sleep_top, ptr_t'(r.entry_index));
        if (found) begin
          pool_link[r.entry_index] = free_top;
          free_top = ptr_t'(r.entry_index);
          live_count--;
        end
        expect_one(found ? ST_OK : ST_NOT_FOUND, 4'd0, 1'b0);
      end
      CMD_ADVANCE: begin
        elapse(r.step_ticks);
        expect_one(ST_OK, 4'd0, 1'b0);
      end
      CMD_DRAIN: begin
        if (ready_top >= ENTRIES) begin
          expect_one(ST_EMPTY, 4'd0, 1'b0);
        end else begin
          while (ready_top < ENTRIES) begin
            id = ready_top;
            c = link_of(id);
            a = '{status: ST_OK, given_index: id[3:0], fired_tag: pool_tag[id],
                  last_fired: 1'b0, is_expired: 1'b0, next_interval: 32'd0};
            drained.push_back(a);
            pool_link[id] = free_top;
            free_top = id;
            ready_top = c;
            live_count--;
          end
          ready_top = NIL;
          foreach (drained[j]) begin
            a = drained[j];
            a.last_fired = (j == drained.size() - 1);
            a.next_interval = head_delay();
            pending_answers.push_back(a);
          end
        end
      end
      CMD_CHECK: begin
        elapse(r.step_ticks);
        if (remove_entry(ready_top, ptr_t'(r.entry_index))) begin
          pool_link[r.entry_index] = free_top;
          free_top = ptr_t'(r.entry_index);
          live_count--;
          expect_one(ST_OK, 4'd0, 1'b1);
        end else begin
          found = 1'b0;
          c = sleep_top;
          while (c < ENTRIES) begin
            if (c == ptr_t'(r.entry_index)) found = 1'b1;
            c = link_of(c);
          end
          if (found) expect_one(ST_OK, 4'd0, 1'b0);
          else expect_one(ST_NOT_FOUND, 4'd0, 1'b1);
        end
      end
      CMD_DUR_START: begin
        span_origin = r.time_now;
        span_on = 1'b1;
        expect_one(ST_OK, 4'd0, 1'b0);
      end
      CMD_DUR_END: begin
        span_on = 1'b0;
        expect_one(ST_OK, 4'd0, 1'b0);
      end
      default: expect_one(ST_OK, 4'd0, 1'b0);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    error_count++;
  endtask

  task automatic send_request(request_t r);
    while ($urandom_range(99, 0) < send_idle_pct) @(negedge clk);
    in_req.valid       = 1'b1;
    in_req.cmd         = r.cmd;
    in_req.delay_ticks = r.delay_ticks;
    in_req.action_tag  = r.action_tag;
    in_req.entry_index = r.entry_index;
    in_req.step_ticks  = r.step_ticks;
    in_req.time_now    = r.time_now;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    predict_queue(r);
    @(negedge clk);
    in_req.valid = 1'b0;
  endtask

  function automatic request_t make_request(logic [2:0] c, logic [31:0] d, logic [15:0] t,
                                            logic [3:0] i, logic [31:0] s, logic [31:0] n);
    request_t r;
    r = '{cmd: c, delay_ticks: d, action_tag: t, entry_index: i, step_ticks: s, time_now: n};
    return r;
  endfunction

  function automatic request_t random_request();
    request_t    r;
    logic [31:0] d;
    logic [31:0] s;
    int          pick;
    pick = $urandom_range(99, 0);
    d = ($urandom_range(3, 0) == 0) ? $urandom() : 32'($urandom_range(40, 0));
    s = ($urandom_range(7, 0) == 0) ? $urandom() : 32'($urandom_range(20, 0));
    r = make_request(CMD_INSERT, d, 16'($urandom()), 4'($urandom()), s, $urandom());
    if (pick >= 45 && pick < 55) r.cmd = CMD_CANCEL;
    else if (pick >= 55 && pick < 72) r.cmd = CMD_ADVANCE;
    else if (pick >= 72 && pick < 84) r.cmd = CMD_DRAIN;
    else if (pick >= 84 && pick < 94) r.cmd = CMD_CHECK;
    else if (pick >= 94 && pick < 97) r.cmd = CMD_DUR_START;
    else if (pick >= 97) r.cmd = CMD_DUR_END;
    if (r.cmd == CMD_INSERT && live_count >= ENTRIES && $urandom_range(3, 0) != 0)
      r.cmd = CMD_DRAIN;
    if ($urandom_range(49, 0) == 0) r.cmd = 3'd7;
    return r;
  endfunction

  task automatic wait_quiet();
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic test_directed();
    send_request(make_request(CMD_DRAIN, 0, 0, 0, 0, 0));
    send_request(make_request(CMD_CANCEL, 0, 0, 4'd15, 0, 0));
    send_request(make_request(CMD_CHECK, 0, 0, 4'd3, 0, 0));
    send_request(make_request(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 0, 0, 0));
    send_request(make_request(CMD_INSERT, 32'd5, 16'h0001, 0, 0, 0));
    send_request(make_request(CMD_INSERT, 32'd5, 16'h0002, 0, 0, 0));
    send_request(make_request(CMD_INSERT, 32'd0, 16'h0000, 0, 0, 0));
    send_request(make_request(CMD_CHECK, 0, 0, 4'd1, 0, 0));
    send_request(make_request(CMD_ADVANCE, 0, 0, 0, 32'd0, 0));
    send_request(make_request(CMD_ADVANCE, 0, 0, 0, 32'd5, 0));
    send_request(make_request(CMD_CHECK, 0, 0, 4'd1, 32'd0, 0));
    send_request(make_request(CMD_CANCEL, 0, 0, 4'd0, 0, 0));
    send_request(make_request(CMD_DRAIN, 0, 0, 0, 0, 0));
    send_request(make_request(CMD_DUR_START, 0, 0, 0, 0, 32'hFFFF_FFF0));
    send_request(make_request(CMD_INSERT, 32'd40, 16'hA5A5, 0, 0, 32'h0000_0008));
    send_request(make_request(CMD_INSERT, 32'd10, 16'h5A5A, 0, 0, 32'h0000_0008));
    send_request(make_request(CMD_DUR_END, 0, 0, 0, 0, 0));
    send_request(make_request(3'd7, 0, 0, 0, 0, 0));
    send_request(make_request(CMD_ADVANCE, 0, 0, 0, 32'hFFFF_FFFF, 0));
    send_request(make_request(CMD_DRAIN, 0, 0, 0, 0, 0));
    for (int k = 0; k < ENTRIES + 1; k++)
      send_request(make_request(CMD_INSERT, 32'(k % 3), 16'(k), 0, 0, 0));
    send_request(make_request(CMD_DRAIN, 0, 0, 0, 0, 0));
    send_request(make_request(CMD_ADVANCE, 0, 0, 0, 32'd3, 0));
    send_request(make_request(CMD_DRAIN, 0, 0, 0, 0, 0));
    wait_quiet();
  endtask

  task automatic test_random_phase(int idle, int stall, int count);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (count) send_request(random_request());
    wait_quiet();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 300;
    repeat (10) send_request(random_request());
    wait_quiet();
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      out_res.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_res.ready <= 1'b0;
    end else begin
      out_res.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_res.status), 32'd0);
      end else begin
        want = pending_answers.pop_front();
        if (out_res.status !== want.status)
          report_mismatch("status", 32'(out_res.status), 32'(want.status));
        if (out_res.given_index !== want.given_index)
          report_mismatch("given_index", 32'(out_res.given_index), 32'(want.given_index));
        if (out_res.fired_tag !== want.fired_tag)
          report_mismatch("fired_tag", 32'(out_res.fired_tag), 32'(want.fired_tag));
        if (out_res.last_fired !== want.last_fired)
          report_mismatch("last_fired", 32'(out_res.last_fired), 32'(want.last_fired));
        if (out_res.is_expired !== want.is_expired)
          report_mismatch("is_expired", 32'(out_res.is_expired), 32'(want.is_expired));
        if (out_res.next_interval !== want.next_interval)
          report_mismatch("next_interval", out_res.next_interval, want.next_interval);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("delay_sorted_action_queue_tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    live_count = 0;
    in_req.valid = 1'b0;
    in_req.cmd = CMD_INSERT;
    in_req.delay_ticks = '0;
    in_req.action_tag = '0;
    in_req.entry_index = '0;
    in_req.step_ticks = '0;
    in_req.time_now = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      pool_link[i] = (i + 1 < ENTRIES) ? ptr_t'(i + 1) : NIL;
      pool_delay[i] = '0;
      pool_tag[i] = '0;
    end
    free_top = '0;
    ready_top = NIL;
    sleep_top = NIL;
    span_origin = '0;
    span_on = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random_phase(0, 0, 20);
    test_random_phase(86, 0, 20);
    test_random_phase(0, 86, 20);
    test_random_phase(8, 8, 20);
    test_backpressure();
    if (error_count == 0) begin
      $display("delay_sorted_action_queue_tb: PASS");
    end else begin
      $display("delay_sorted_action_queue_tb: FAIL");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+src
src/dsaq_pkg.sv
src/dsaq_req_if.sv
src/dsaq_res_if.sv
src/dsaq_front.sv
src/dsaq_fifo.sv
src/dsaq_back.sv
src/delay_sorted_action_queue.sv
src/dsaq_checker.sv
test/dsaq_tb_if.sv
test/delay_sorted_action_queue_tb.sv
